FILE: rtl/dqs_pkg.sv
// Shared types and codes for the circular deque with search.
`default_nettype none
package dqs_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;
  localparam int KIND_W        = 3;
  localparam int STATUS_W      = 2;
  localparam int POS_W         = 4;
  localparam int COUNT_W       = 5;

  // Operation codes carried by an input item
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

  // What every cell of the chain does this cycle
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_SHIFT_RIGHT,
    CMD_SHIFT_LEFT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      sel;   // this cell is the back slot for a load
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/dqs_cell.sv
// One storage cell of the deque chain: holds, loads, or takes a neighbor's entry.
`default_nettype none
module dqs_cell
  import dqs_pkg::*;
(
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] load_value,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data
);

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_LOAD: begin
        if (ctl.sel) begin
          data <= load_value;
        end
      end
      CMD_SHIFT_RIGHT: data <= left_data;
      CMD_SHIFT_LEFT:  data <= right_data;
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/circular_deque_with_search.sv
// Top level of the circular deque with search: cell chain, control and result register.
`default_nettype none
// The deque lives in a row of DEPTH cells kept in queue order, the front
// entry always in cell 0. Push front shifts the row one cell toward the
// back and drops the new item into cell 0; pop front shifts it toward the
// front; push back loads the cell at the current count; pop back only
// lowers the count. The result of these is registered at the edge that
// accepts the item. A search rotates the whole row once through cell 0,
// comparing one entry with the key per cycle, and its result is registered
// when the rotation ends; the full rotation puts the entries back in place.
// A new item is taken only while no result is pending, or in the cycle the
// pending one is taken, so entry_count and front_value, which show the
// registered state, stay put while out_valid is high. The cells come up
// with no defined contents; only live cells are ever read.
module circular_deque_with_search
  import dqs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
)(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic [KIND_W-1:0]          kind,
  input  wire logic signed [DATA_W-1:0]   value,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic [STATUS_W-1:0]        status,
  output      logic [POS_W-1:0]           found_position,
  output      logic [COUNT_W-1:0]         entry_count,
  output      logic signed [DATA_W-1:0]   front_value
);

  localparam int CW = $clog2(DEPTH + 1);   // count, 0..DEPTH
  localparam int SW = $clog2(DEPTH);       // search step, 0..DEPTH-1

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  state_t                   state;
  logic [CW-1:0]            count;
  logic [SW-1:0]            step;
  logic [SW-1:0]            pos;
  logic                     hit;
  logic signed [DATA_W-1:0] key;
  logic [STATUS_W-1:0]      status_reg;

  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     hit_now;
  cell_cmd_t                cmd;

  cell_ctl_t                ctl       [DEPTH];
  logic signed [DATA_W-1:0] cell_data [DEPTH];

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);

  // Cell 0 is compared with the key once per search cycle; only live entries count.
  assign hit_now = !hit && ({1'b0, step} < (SW + 1)'(count)) && (cell_data[0] == key);

  always_comb begin
    cmd = CMD_HOLD;
    if (state == S_SEARCH) begin
      cmd = CMD_SHIFT_LEFT;           // rotate the row through cell 0
    end else if (accept) begin
      case (kind)
        KIND_PUSH_BACK:  if (!full)  cmd = CMD_LOAD;
        KIND_PUSH_FRONT: if (!full)  cmd = CMD_SHIFT_RIGHT;
        KIND_POP_FRONT:  if (!empty) cmd = CMD_SHIFT_LEFT;
        default:         cmd = CMD_HOLD;
      endcase
    end
  end

  // Cell row: the left end takes the pushed item, the right end wraps to cell 0.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;

    assign ctl[k].cmd = cmd;
    assign ctl[k].sel = (count == CW'(k));

    if (k == 0) begin : g_first
      assign left_in = value;
    end else begin : g_mid_l
      assign left_in = cell_data[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_in = cell_data[0];
    end else begin : g_mid_r
      assign right_in = cell_data[k+1];
    end

    dqs_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[k]),
      .load_value (value),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      hit       <= 1'b0;
      step      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (accept) begin
            status_reg <= ST_OK;
            pos        <= '0;
            out_valid  <= 1'b1;
            case (kind)
              KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                if (full) begin
                  status_reg <= ST_FULL;
                end else begin
                  count <= count + 1'b1;
                end
              end
              KIND_POP_BACK, KIND_POP_FRONT: begin
                if (empty) begin
                  status_reg <= ST_EMPTY;
                end else begin
                  count <= count - 1'b1;
                end
              end
              KIND_SEARCH: begin
                out_valid <= 1'b0;
                key       <= value;
                step      <= '0;
                hit       <= 1'b0;
                state     <= S_SEARCH;
              end
              default: begin
              end
            endcase
          end
        end
        S_SEARCH: begin
          step <= step + 1'b1;
          if (hit_now) begin
            hit <= 1'b1;
            pos <= step;
          end
          if (step == SW'(DEPTH - 1)) begin
            // row is back in place after this shift
            status_reg <= (hit || hit_now) ? ST_OK : ST_MISS;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status         = status_reg;
  assign found_position = POS_W'(pos);
  assign entry_count    = COUNT_W'(count);
  assign front_value    = empty ? '0 : cell_data[0];

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the circular deque with search: shadow deque, random traffic.
`timescale 1ns / 100ps
module tb;
  import dqs_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 1950;  // counts only items with a defined operation
  localparam int PAUSE_EVERY  = 480;   // sender drains the block this often
  localparam int REPORT_LIMIT = 10;    // mismatches beyond this are only counted

  // One result item as the block presents it
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [POS_W-1:0]         position;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] front;
  } deque_outcome_t;

  // Traffic mixes: each one pushes the fill level a different way
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN, MIX_SEARCH} traffic_mix_t;
  // Receiver behaviors
  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_CHOKED} rx_mode_t;

  // Shadow copy of the deque. apply_op runs on every accepted input item and
  // queues the result that item must produce; check_outcome pops the oldest.
  class deque_mirror_t;
    logic signed [DATA_W-1:0] slots [DEPTH];
    int unsigned              head = 0;
    int unsigned              fill = 0;
    deque_outcome_t           expected_outcomes [$];
    int unsigned              mismatches = 0;

    function void apply_op(logic [KIND_W-1:0] op, logic signed [DATA_W-1:0] operand);
      deque_outcome_t outcome;
      int unsigned    i;
      outcome = '0;
      case (op)
        KIND_PUSH_BACK: begin
          if (fill >= DEPTH) begin
            outcome.status = ST_FULL;
          end else begin
            slots[(head + fill) % DEPTH] = operand;
            fill++;
          end
        end
        KIND_PUSH_FRONT: begin
          if (fill >= DEPTH) begin
            outcome.status = ST_FULL;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            slots[head] = operand;
            fill++;
          end
        end
        KIND_POP_BACK: begin
          if (fill == 0) outcome.status = ST_EMPTY;
          else fill--;
        end
        KIND_POP_FRONT: begin
          if (fill == 0) begin
            outcome.status = ST_EMPTY;
          end else begin
            head = (head + 1) % DEPTH;
            fill--;
          end
        end
        KIND_SEARCH: begin
          // first match counted from the front wins
          outcome.status = ST_MISS;
          for (i = 0; i < fill; i++) begin
            if (outcome.status == ST_MISS && slots[(head + i) % DEPTH] == operand) begin
              outcome.status   = ST_OK;
              outcome.position = i[POS_W-1:0];
            end
          end
        end
        default: ;  // unused codes leave the deque alone
      endcase
      outcome.count = fill[COUNT_W-1:0];
      outcome.front = (fill != 0) ? slots[head] : '0;
      expected_outcomes.push_back(outcome);
    endfunction

    function void check_outcome(deque_outcome_t got);
      deque_outcome_t want;
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"[tb] %0t: result with nothing pending: ",
                    "st=%0d pos=%0d cnt=%0d front=%0d"},
                   $time, got.status, got.position, got.count, got.front);
        return;
      end
      want = expected_outcomes.pop_front();
      if (got.status !== want.status || got.position !== want.position ||
          got.count !== want.count || got.front !== want.front) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"[tb] %0t: mismatch exp st=%0d pos=%0d cnt=%0d front=%0d, ",
                    "got st=%0d pos=%0d cnt=%0d front=%0d"},
                   $time, want.status, want.position, want.count, want.front,
                   got.status, got.position, got.count, got.front);
      end
    endfunction
  endclass

  // Every block input starts at a known value
  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     out_ready = 1'b0;
  logic [KIND_W-1:0]        kind      = '0;
  logic signed [DATA_W-1:0] value     = '0;
  logic                     in_ready;
  logic                     out_valid;
  logic [STATUS_W-1:0]      status;
  logic [POS_W-1:0]         found_position;
  logic [COUNT_W-1:0]       entry_count;
  logic signed [DATA_W-1:0] front_value;

  deque_mirror_t mirror = new();

  // Values pushed so far (recent ones), so searches mostly hit at varied depths
  logic signed [DATA_W-1:0] pushed_recent [$];

  circular_deque_with_search #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .found_position(found_position),
    .entry_count   (entry_count),
    .front_value   (front_value)
  );

  always #6 clk = ~clk;

  // Handshake monitor. Runs in the active region of the edge, so it sees the
  // pre-edge values of both the block outputs and the nonblocking-driven inputs.
  // The result is checked before the new item is noted: a result accepted at
  // this edge always belongs to an older item.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        mirror.check_outcome({status, found_position, entry_count, front_value});
      if (in_valid && in_ready)
        mirror.apply_op(kind, value);
    end
  end

  // Receiver: switches between behaviors for random stretches, from always
  // ready to nearly always stalled.
  initial begin
    rx_mode_t    mode;
    int unsigned span;
    wait (!rst);
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= ($urandom_range(0, 1) != 0);
          RX_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
          default:   out_ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // Present one item and hold it until the edge that takes it. Called at a
  // rising edge; returns at the accepting edge.
  task automatic send_item(input logic [KIND_W-1:0] op, input logic signed [DATA_W-1:0] operand);
    in_valid <= 1'b1;
    kind     <= op;
    value    <= operand;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every queued outcome has come back. The first edge lets
  // the monitor record an item accepted at the calling edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (mirror.expected_outcomes.size() != 0);
  endtask

  // Corner values that push and search both lean on, so duplicates are common
  function automatic logic signed [DATA_W-1:0] pool_value();
    case ($urandom_range(0, 5))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return 32'shFFFF_FFFF;
      4:       return 32'sh0000_0001;
      default: return 32'sh5A5A_5A5A;
    endcase
  endfunction

  initial begin
    int unsigned              sent;
    int unsigned              epoch_end;
    int unsigned              next_pause;
    int unsigned              burst;
    int unsigned              roll;
    int unsigned              push_pct;
    int unsigned              pop_pct;
    traffic_mix_t             mix;
    logic [KIND_W-1:0]        op;
    logic signed [DATA_W-1:0] operand;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed part ----
    // Underflow and search on an empty deque, then an unused code
    send_item(KIND_POP_BACK, 32'sd0);
    send_item(KIND_POP_FRONT, 32'sd0);
    send_item(KIND_SEARCH, 32'sd0);
    send_item(KIND_SEARCH + 3'd1, 32'shFFFF_FFFF);
    // Both extremes, one from each end: the front must become the minimum
    send_item(KIND_PUSH_BACK, 32'sh7FFF_FFFF);
    send_item(KIND_PUSH_FRONT, 32'sh8000_0000);
    // Fill to capacity from alternating ends; the last back push is 39
    for (int i = 0; i < DEPTH - 2; i++) begin
      if (i % 2) send_item(KIND_PUSH_FRONT, -(i + 1));
      else send_item(KIND_PUSH_BACK, 3 * (i + 1));
    end
    // Overflow from both ends is dropped
    send_item(KIND_PUSH_BACK, 32'sh1234_5678);
    send_item(KIND_PUSH_FRONT, 32'sh1234_5678);
    // Hit on the very last slot, then a miss on a full deque
    send_item(KIND_SEARCH, 32'sd39);
    send_item(KIND_SEARCH, 32'sh1234_5678);
    send_item(KIND_POP_BACK, 32'sd0);
    send_item(KIND_POP_FRONT, 32'sd0);
    wait_drained();

    // ---- Random part ----
    // Traffic comes in bursts with random gaps (some bursts run back to back).
    // The mix changes every few dozen items, so the fill level wanders all the
    // way between empty and full and searches see every depth.
    sent       = 0;
    epoch_end  = 0;
    next_pause = PAUSE_EVERY;
    mix        = MIX_EVEN;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= epoch_end) begin
        mix       = traffic_mix_t'($urandom_range(0, 3));
        epoch_end = sent + $urandom_range(30, 90);
      end
      case (mix)
        MIX_GROW:   begin push_pct = 65; pop_pct = 15; end
        MIX_SHRINK: begin push_pct = 15; pop_pct = 65; end
        MIX_EVEN:   begin push_pct = 40; pop_pct = 35; end
        default:    begin push_pct = 25; pop_pct = 20; end
      endcase
      burst = $urandom_range(1, 48);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        if (roll < 3)
          op = KIND_SEARCH + KIND_W'($urandom_range(1, 3));  // unused code, noise
        else if (roll < 3 + push_pct)
          op = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        else if (roll < 3 + push_pct + pop_pct)
          op = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
        else
          op = KIND_SEARCH;

        operand = $urandom;
        if (op == KIND_PUSH_BACK || op == KIND_PUSH_FRONT) begin
          if ($urandom_range(0, 9) < 4) operand = pool_value();
          pushed_recent.push_back(operand);
          if (pushed_recent.size() > 2 * DEPTH) void'(pushed_recent.pop_front());
        end else if (op == KIND_SEARCH) begin
          roll = $urandom_range(0, 99);
          if (roll < 55 && pushed_recent.size() != 0)
            operand = pushed_recent[$urandom_range(0, pushed_recent.size() - 1)];
          else if (roll < 75)
            operand = pool_value();
        end

        send_item(op, operand);
        if (op <= KIND_SEARCH) sent++;
      end
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 10));
      // Every so often let the block run completely dry before going on
      if (sent >= next_pause) begin
        wait_drained();
        next_pause += PAUSE_EVERY;
      end
    end

    // ---- Wind-down ----
    // Everything accepted; wait out the outstanding results, then keep watching
    // past the length of a search so a stray extra result would still be caught.
    wait_drained();
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.expected_outcomes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: a correct run ends far sooner than this (12 ms)
  initial begin
    #(12_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
